// File: rtl/core/bdcl_pkg.sv
package bdcl_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int CNT_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] STABLE_TICKS_RST = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_TICKS_RST = 16'd1000;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STABLE_TICKS     = 1'd0,
    REG_LONG_PRESS_TICKS = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_STEP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PRESSED = 2'd1,
    ST_CLICK   = 2'd2,
    ST_LONG    = 2'd3
  } press_state_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] button;
    logic       pin_level;
  } cmd_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       debounced_pressed;
    logic [1:0] press_state;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] hold_count;
    logic             level_pressed;
    logic [1:0]       recognizer_state;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/core/bdcl_ram.sv
module bdcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/bdcl_update.sv
module bdcl_update (
  input  bdcl_pkg::entry_t             cur,
  input  logic [1:0]                   kind,
  input  logic                         pin_level,
  input  logic [bdcl_pkg::CFG_W-1:0]   stable_ticks,
  input  logic [bdcl_pkg::CFG_W-1:0]   long_press_ticks,
  output bdcl_pkg::entry_t             nxt,
  output logic [1:0]                   event_res
);
  import bdcl_pkg::*;

  always_comb begin
    nxt = cur;
    event_res = EV_NONE;
    case (kind)
      KIND_TICK: begin
        if (cur.hold_count != CNT_MAX) begin
          nxt.hold_count = cur.hold_count + CNT_W'(1);
        end
      end
      KIND_SAMPLE: begin
        if (cur.hold_count >= stable_ticks && cur.level_pressed != pin_level) begin
          nxt.level_pressed = pin_level;
          nxt.hold_count = '0;
        end
      end
      KIND_STEP: begin
        case (cur.recognizer_state)
          ST_IDLE: begin
            if (cur.level_pressed) begin
              nxt.recognizer_state = ST_PRESSED;
            end
          end
          ST_PRESSED: begin
            if (!cur.level_pressed) begin
              nxt.recognizer_state = ST_CLICK;
            end else if (cur.hold_count >= long_press_ticks) begin
              event_res = EV_LONG;
              nxt.recognizer_state = ST_LONG;
            end
          end
          ST_CLICK: begin
            event_res = EV_CLICK;
            nxt.recognizer_state = ST_IDLE;
          end
          default: begin
            if (!cur.level_pressed) begin
              nxt.recognizer_state = ST_IDLE;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/button_debounce_click_longpress_core.sv
// Pipeline: two register stages (state RAM read, result); res_valid is registered
// from s1_valid, which is set when the command transaction is accepted.
// Throughput: one transaction per cycle while res_stall does not hold the result,
// set by the per-button state RAM read and write-back, with forwarding between them.
// Reset (rst, synchronous): clears pipeline valids, loads register defaults and
// clears one valid bit per button, so every button reads as zero at once.
module button_debounce_click_longpress_core #(
  parameter int NUM_BUTTONS = bdcl_pkg::NUM_BUTTONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  bdcl_pkg::cmd_t                 cmd,
  output logic                           res_valid,
  input  logic                           res_stall,
  output bdcl_pkg::res_t                 res,
  input  logic                           cfg_we,
  input  logic [bdcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdcl_pkg::CFG_W-1:0]     cfg_data
);
  import bdcl_pkg::*;

  localparam int AW = NUM_BUTTONS > 1 ? $clog2(NUM_BUTTONS) : 1;

  logic [CFG_W-1:0] stable_ticks;
  logic [CFG_W-1:0] long_press_ticks;

  logic             accept;
  logic             s1_go;
  logic             cmd_in_range;
  logic [AW-1:0]    cmd_addr;

  logic             s1_valid;
  logic [1:0]       s1_kind;
  logic             s1_pin;
  logic             s1_in_range;
  logic [AW-1:0]    s1_addr;
  logic             s1_ent_valid;
  logic             s1_fwd_hit;
  entry_t           s1_fwd_data;

  logic [NUM_BUTTONS-1:0] entry_valid;

  logic             wr_en;
  entry_t           rd_data;
  entry_t           cur;
  entry_t           nxt;
  logic [1:0]       upd_event;

  assign cmd_in_range = {5'd0, cmd.button} < 7'(NUM_BUTTONS);
  assign cmd_addr     = AW'(cmd.button);
  assign s1_go        = !res_valid || !res_stall;
  assign cmd_stall    = s1_valid && !s1_go;
  assign accept       = cmd_valid && !cmd_stall;
  assign wr_en        = s1_valid && s1_go && s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_ticks <= STABLE_TICKS_RST;
      long_press_ticks <= LONG_PRESS_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STABLE_TICKS:     stable_ticks <= cfg_data;
        REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bdcl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_BUTTONS)
  ) u_state_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_addr),
    .wdata(nxt),
    .re   (accept),
    .raddr(cmd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // capture item and any write landing on the same entry at the read edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind      <= cmd.kind;
      s1_pin       <= cmd.pin_level;
      s1_in_range  <= cmd_in_range;
      s1_addr      <= cmd_addr;
      s1_ent_valid <= cmd_in_range && entry_valid[cmd_addr];
      s1_fwd_hit   <= wr_en && s1_addr == cmd_addr;
      s1_fwd_data  <= nxt;
    end
  end

  always_comb begin
    if (s1_fwd_hit) begin
      cur = s1_fwd_data;
    end else if (s1_ent_valid) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
  end

  bdcl_update u_update (
    .cur             (cur),
    .kind            (s1_kind),
    .pin_level       (s1_pin),
    .stable_ticks    (stable_ticks),
    .long_press_ticks(long_press_ticks),
    .nxt             (nxt),
    .event_res       (upd_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid) begin
      if (s1_in_range) begin
        res.event_res         <= upd_event;
        res.debounced_pressed <= nxt.level_pressed;
        res.press_state       <= nxt.recognizer_state;
      end else begin
        res <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> s1_valid && res_valid && res_stall)
    else $error("command stalled with free pipeline");

  a_long_state: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res == EV_LONG |-> res.press_state == ST_LONG)
    else $error("long press without long state");

  a_click_state: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res == EV_CLICK |-> res.press_state == ST_IDLE)
    else $error("click without return to idle");

  a_fwd_only_same_entry: assert property (@(posedge clk) disable iff (rst)
    accept && wr_en && s1_addr == cmd_addr |=> s1_fwd_hit)
    else $error("missed forwarding of same-entry write");
`endif

endmodule
